/* hdl/vfra_pkg.sv */
// Package for the variable frame ring allocator: shared types, widths and codes.
// Used by every module of the block and by the checker; no dependencies.
`default_nettype none
package vfra_pkg;

  // Internal offset arithmetic width: holds need plus guard for any 18-bit request.
  localparam int AW    = 21;
  localparam int LEN_W = 19;

  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_DONE    = 3'd1;
  localparam logic [2:0] ACT_RECLAIM = 3'd2;
  localparam logic [2:0] ACT_TAIL    = 3'd3;
  localparam logic [2:0] ACT_UNDO    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;
  localparam logic [1:0] ST_BAD_HDR = 2'd3;

  typedef struct packed {
    logic             valid;
    logic             done;
    logic [LEN_W-1:0] len;
  } hdr_word_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] idx;
    hdr_word_t     wdata;
  } hdr_req_t;

  function automatic logic [AW-1:0] free_f(input logic [AW-1:0] head,
                                          input logic [AW-1:0] tail,
                                          input logic [AW-1:0] arena);
    free_f = (head >= tail) ? (arena - (head - tail)) : (tail - head);
  endfunction

endpackage
`default_nettype wire

/* hdl/vfra_hdr_mem.sv */
// Header store: one word per aligned slot, single write and registered read.
// Clears every slot after reset, one slot a cycle. Depends on vfra_pkg.
`default_nettype none
module vfra_hdr_mem #(
  parameter int SLOTS = 4096,
  parameter int IW    = 12
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  vfra_pkg::hdr_req_t   req,
  output vfra_pkg::hdr_word_t  rd_data,
  output logic                 ready
);

  vfra_pkg::hdr_word_t mem [SLOTS];
  vfra_pkg::hdr_word_t rd_r;
  logic                clr_busy_r, clr_busy_nxt;
  logic [IW-1:0]       clr_idx_r, clr_idx_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == IW'(SLOTS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.we) begin
      mem[req.idx[IW-1:0]] <= req.wdata;
    end
    rd_r <= mem[req.idx[IW-1:0]];
  end

  assign rd_data = rd_r;
  assign ready   = !clr_busy_r;

endmodule
`default_nettype wire

/* hdl/vfra_mod.sv */
// Iterative remainder unit: one restoring subtract step per cycle.
// Used for tail wrap and undo mark reduction. Depends on vfra_pkg.
`default_nettype none
module vfra_mod (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire  [vfra_pkg::AW-1:0]   num,
  input  wire  [vfra_pkg::AW-1:0]   den,
  output logic                      done,
  output logic [vfra_pkg::AW-1:0]   rem
);

  localparam int AW = vfra_pkg::AW;
  localparam int KW = $clog2(AW);

  logic [AW-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   den_r, den_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [2*AW-1:0] dsh;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dsh      = {{AW{1'b0}}, den_r} << k_r;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      k_nxt    = KW'(AW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract the shifted divisor where it fits
      if ({{AW{1'b0}}, rem_r} >= dsh) begin
        rem_nxt = rem_r - dsh[AW-1:0];
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    k_r   <= k_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* hdl/variable_frame_ring_allocator.sv */
// Top level of the variable frame ring allocator: sequencer, pointers, output register.
// Depends on vfra_pkg, vfra_hdr_mem and vfra_mod.
//
// Use: a ring arena that hands out variable-length frames by offset only.
// in_*  : one action per transfer; in_tuser carries the action code, in_tdata the operands.
// out_* : exactly one result per action; out_tuser carries the status.
// cfg_* : writes the arena size; a write also returns head, tail and sequence to zero.
//   Write it only while no action is in flight.
// Sequence: each action is decoded, then ends in a finishing state that loads the output
//   register. Tail-to-head and undefined actions go straight there; done reads its frame
//   header and marks a valid one done; undo reduces the mark in the shared modulo unit.
//   Reclaim walks the tail: each tail header retired or wrap gap taken is one check and
//   one header store read, and a frame length that wraps more than once round the arena
//   also passes through the shared modulo unit. Alloc walks the tail the same way, then
//   checks the fit and places the frame, writing a pad header first when it wraps.
//   The block holds one action at a time; in_tready is high only while it waits.
// Reset: synchronous, active low. After reset the header store is cleared one slot a
//   cycle, all ARENA_MAX_BYTES/ALIGN_BYTES slots (4096 by default); in_tready stays low
//   meanwhile, configuration writes are taken.
// Stall: a finished result is held in the output register until taken; the next
//   action may be accepted meanwhile and waits at its end for the register to free.
`default_nettype none
module variable_frame_ring_allocator #(
  parameter int ARENA_MAX_BYTES = 131072,
  parameter int ALIGN_BYTES     = 32,
  parameter int HEADER_BYTES    = 32
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           cfg_tvalid,
  output logic          cfg_tready,
  input  wire  [17:0]   cfg_tdata,   // arena_bytes
  input  wire           in_tvalid,
  output logic          in_tready,
  input  wire  [2:0]    in_tuser,    // action
  input  wire  [103:0]  in_tdata,    // pay_len, guard_bytes, target_free,
                                     // reclaim_budget, frame_offset, mark_offset, pad
  output logic          out_tvalid,
  input  wire           out_tready,
  output logic [1:0]    out_tuser,   // status
  output logic [103:0]  out_tdata    // payload_offset, frame_seq, head_offset,
                                     // free_space, reclaimed_frames, pad
);

  localparam int AW       = vfra_pkg::AW;
  localparam int LEN_W    = vfra_pkg::LEN_W;
  localparam int SH       = $clog2(ALIGN_BYTES);
  localparam int SLOTS    = ARENA_MAX_BYTES / ALIGN_BYTES;
  localparam int IW       = $clog2(SLOTS);
  localparam int CW       = $clog2(SLOTS + 1);
  localparam int HDR_SPAN = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int CAP      = SLOTS * ALIGN_BYTES;

  localparam logic [AW-1:0] AMASK = AW'(ALIGN_BYTES - 1);
  localparam logic [AW-1:0] HDR   = AW'(HDR_SPAN);
  localparam logic [AW-1:0] CAPV  = AW'(CAP);
  localparam logic [AW-1:0] ALGV  = AW'(ALIGN_BYTES);
  localparam logic [AW-1:0] SLOTV = AW'(SLOTS);

  typedef enum logic [11:0] {
    S_CLR     = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_DEC     = 12'b0000_0000_0100,
    S_RC_CHK  = 12'b0000_0000_1000,
    S_RC_STEP = 12'b0000_0001_0000,
    S_RC_MOD  = 12'b0000_0010_0000,
    S_AL_FIT  = 12'b0000_0100_0000,
    S_AL_PAD  = 12'b0000_1000_0000,
    S_AL_HDR  = 12'b0001_0000_0000,
    S_DN_RD   = 12'b0010_0000_0000,
    S_UN_MOD  = 12'b0100_0000_0000,
    S_FIN     = 12'b1000_0000_0000
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt, tail_r, tail_nxt, arena_r, arena_nxt;
  logic [31:0]    seq_r, seq_nxt, fseq_r, fseq_nxt;
  logic [2:0]     act_r, act_nxt;
  logic [AW-1:0]  pl_r, pl_nxt, guard_r, guard_nxt, tgt_r, tgt_nxt;
  logic [AW-1:0]  fo_r, fo_nxt, mark_r, mark_nxt, at_r, at_nxt, nh_r, nh_nxt;
  logic [AW-1:0]  pay_r, pay_nxt;
  logic [CW-1:0]  lim_r, lim_nxt, cnt_r, cnt_nxt;
  logic           mode_r, mode_nxt, ret_r, ret_nxt;
  logic           dn_ok_r, dn_ok_nxt;
  logic [1:0]     status_r, status_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_user_r, out_user_nxt;
  logic [103:0]   out_data_r, out_data_nxt;

  vfra_pkg::hdr_req_t  req;
  vfra_pkg::hdr_word_t rd;
  logic                mem_ready;
  logic                mod_start, mod_done;
  logic [AW-1:0]       mod_num, mod_rem;

  // working values
  logic [AW-1:0] need, ng, fr, endv, h2, t_sum, t1, dn_h, cfg_a, tail_idx;
  logic          fit_a, stop, in_acc, cfg_acc;

  vfra_hdr_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk(clk), .rst_n(rst_n), .req(req), .rd_data(rd), .ready(mem_ready)
  );

  vfra_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .num(mod_num), .den(arena_r),
    .done(mod_done), .rem(mod_rem)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = (state_r == S_IDLE) || (state_r == S_CLR);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_tvalid && cfg_tready;

  assign need     = HDR + pl_r;
  assign ng       = need + guard_r;
  assign fr       = vfra_pkg::free_f(head_r, tail_r, arena_r);
  assign endv     = arena_r - head_r;
  assign tail_idx = tail_r >> SH;
  assign t_sum    = tail_r + AW'(rd.len) + HDR;
  assign t1       = (t_sum >= arena_r) ? (t_sum - arena_r) : t_sum;
  assign dn_h     = fo_r - HDR;
  assign fit_a    = (head_r >= tail_r) ? ((endv >= need) && (fr >= ng))
                                       : ((tail_r - head_r) >= ng);

  // Normalise the written arena size: round up, cap, floor at one alignment unit.
  always_comb begin
    cfg_a = (AW'(cfg_tdata) + AMASK) & ~AMASK;
    if (cfg_a > CAPV) cfg_a = CAPV;
    if (cfg_a < ALGV) cfg_a = ALGV;
  end

  // Loop exit of the tail walk.
  always_comb begin
    stop = (cnt_r >= lim_r) || (tail_r == head_r);
    if (mode_r && fit_a) stop = 1'b1;
    if (!mode_r && ret_r && (tgt_r != '0) && (fr >= tgt_r)) stop = 1'b1;
  end

  // Header store requests and modulo starts.
  always_comb begin
    req       = '0;
    req.idx   = tail_idx;
    mod_start = 1'b0;
    mod_num   = mark_r;
    priority case (1'b1)
      (state_r == S_DEC): begin
        req.idx   = dn_h >> SH;
        mod_start = (act_r == vfra_pkg::ACT_UNDO);
      end
      (state_r == S_DN_RD): begin
        req.idx         = dn_h >> SH;
        req.we          = dn_ok_r && rd.valid;
        req.wdata.valid = 1'b1;
        req.wdata.done  = 1'b1;
        req.wdata.len   = rd.len;
      end
      (state_r == S_AL_PAD): begin
        req.idx = head_r >> SH;
        req.we  = 1'b1;
        // no room for a pad header: invalidate the old head slot
        if (endv >= HDR) begin
          req.wdata.valid = 1'b1;
          req.wdata.done  = 1'b1;
          req.wdata.len   = LEN_W'(endv - HDR);
        end
      end
      (state_r == S_AL_HDR): begin
        req.idx         = at_r >> SH;
        req.we          = 1'b1;
        req.wdata.valid = 1'b1;
        req.wdata.len   = LEN_W'(pl_r);
      end
      (state_r == S_RC_STEP): begin
        mod_num   = t1;
        mod_start = (tail_idx < SLOTV) && rd.valid && rd.done && (t1 >= arena_r);
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    arena_nxt     = arena_r;
    seq_nxt       = seq_r;
    fseq_nxt      = fseq_r;
    act_nxt       = act_r;
    pl_nxt        = pl_r;
    guard_nxt     = guard_r;
    tgt_nxt       = tgt_r;
    fo_nxt        = fo_r;
    mark_nxt      = mark_r;
    at_nxt        = at_r;
    nh_nxt        = nh_r;
    pay_nxt       = pay_r;
    lim_nxt       = lim_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    ret_nxt       = ret_r;
    dn_ok_nxt     = dn_ok_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    h2            = head_r + need;

    if (cfg_acc) begin
      arena_nxt = cfg_a;
      head_nxt  = '0;
      tail_nxt  = '0;
      seq_nxt   = '0;
    end

    unique case (state_r)
      S_CLR: begin
        if (mem_ready) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          act_nxt   = in_tuser;
          pl_nxt    = (AW'(in_tdata[17:0]) + AMASK) & ~AMASK;
          guard_nxt = (AW'(in_tdata[35:18]) + AMASK) & ~AMASK;
          tgt_nxt   = AW'(in_tdata[53:36]);
          if (in_tdata[66:54] == '0 || 32'(in_tdata[66:54]) > 32'(SLOTS)) begin
            lim_nxt = CW'(SLOTS);
          end else begin
            lim_nxt = CW'(in_tdata[66:54]);
          end
          fo_nxt    = AW'(in_tdata[83:67]);
          mark_nxt  = AW'(in_tdata[101:84]);
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        status_nxt = vfra_pkg::ST_OK;
        pay_nxt    = '0;
        fseq_nxt   = '0;
        cnt_nxt    = '0;
        ret_nxt    = 1'b0;
        mode_nxt   = 1'b0;
        dn_ok_nxt  = (fo_r >= HDR) && ((dn_h & AMASK) == '0) && (dn_h < arena_r)
                     && ((dn_h >> SH) < SLOTV);
        unique case (act_r)
          vfra_pkg::ACT_ALLOC: begin
            mode_nxt  = 1'b1;
            lim_nxt   = CW'(SLOTS);
            state_nxt = S_RC_CHK;
          end
          vfra_pkg::ACT_DONE:    state_nxt = S_DN_RD;
          vfra_pkg::ACT_RECLAIM: state_nxt = S_RC_CHK;
          vfra_pkg::ACT_TAIL: begin
            tail_nxt  = head_r;
            state_nxt = S_FIN;
          end
          vfra_pkg::ACT_UNDO:    state_nxt = S_UN_MOD;
          default:               state_nxt = S_FIN;
        endcase
      end
      S_RC_CHK: begin
        if (stop) begin
          state_nxt = mode_r ? S_AL_FIT : S_FIN;
        end else begin
          state_nxt = S_RC_STEP;
        end
      end
      S_RC_STEP: begin
        ret_nxt = 1'b0;
        if (!(tail_idx < SLOTV) || !rd.valid) begin
          // wrap gap: no header at tail while head is behind it
          if (head_r < tail_r && ((arena_r - tail_r) & AMASK) == '0) begin
            tail_nxt  = '0;
            state_nxt = S_RC_CHK;
          end else begin
            state_nxt = mode_r ? S_AL_FIT : S_FIN;
          end
        end else if (!rd.done) begin
          state_nxt = mode_r ? S_AL_FIT : S_FIN;
        end else if (t1 >= arena_r) begin
          state_nxt = S_RC_MOD;
        end else begin
          tail_nxt  = t1 & ~AMASK;
          cnt_nxt   = cnt_r + 1'b1;
          ret_nxt   = 1'b1;
          state_nxt = S_RC_CHK;
        end
      end
      S_RC_MOD: begin
        if (mod_done) begin
          tail_nxt  = mod_rem & ~AMASK;
          cnt_nxt   = cnt_r + 1'b1;
          ret_nxt   = 1'b1;
          state_nxt = S_RC_CHK;
        end
      end
      S_AL_FIT: begin
        status_nxt = vfra_pkg::ST_NO_ROOM;
        state_nxt  = S_FIN;
        if (h2 >= arena_r) h2 = '0;
        if (need > arena_r) begin
          status_nxt = vfra_pkg::ST_TOO_BIG;
        end else if (head_r < tail_r) begin
          if (ng <= (tail_r - head_r) && (head_r + need) != tail_r) begin
            at_nxt     = head_r;
            nh_nxt     = head_r + need;
            status_nxt = vfra_pkg::ST_OK;
            state_nxt  = S_AL_HDR;
          end
        end else if (((ng <= endv) || (endv >= need && fr >= ng)) && h2 != tail_r) begin
          at_nxt     = head_r;
          nh_nxt     = h2;
          status_nxt = vfra_pkg::ST_OK;
          state_nxt  = S_AL_HDR;
        end else if (need <= tail_r && fr >= ng && need != tail_r) begin
          at_nxt     = '0;
          nh_nxt     = need;
          status_nxt = vfra_pkg::ST_OK;
          state_nxt  = S_AL_PAD;
        end
      end
      S_AL_PAD: begin
        state_nxt = S_AL_HDR;
      end
      S_AL_HDR: begin
        seq_nxt   = seq_r + 1'b1;
        fseq_nxt  = seq_r + 1'b1;
        pay_nxt   = at_r + HDR;
        head_nxt  = nh_r;
        state_nxt = S_FIN;
      end
      S_DN_RD: begin
        status_nxt = (dn_ok_r && rd.valid) ? vfra_pkg::ST_OK : vfra_pkg::ST_BAD_HDR;
        state_nxt  = S_FIN;
      end
      S_UN_MOD: begin
        if (mod_done) begin
          head_nxt  = mod_rem & ~AMASK;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold here until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {6'b0, 13'(cnt_r), fr[17:0], head_r[17:0], fseq_r, pay_r[16:0]};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      head_r      <= '0;
      tail_r      <= '0;
      arena_r     <= CAPV;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      arena_r     <= arena_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fseq_r     <= fseq_nxt;
    act_r      <= act_nxt;
    pl_r       <= pl_nxt;
    guard_r    <= guard_nxt;
    tgt_r      <= tgt_nxt;
    fo_r       <= fo_nxt;
    mark_r     <= mark_nxt;
    at_r       <= at_nxt;
    nh_r       <= nh_nxt;
    pay_r      <= pay_nxt;
    lim_r      <= lim_nxt;
    cnt_r      <= cnt_nxt;
    mode_r     <= mode_nxt;
    ret_r      <= ret_nxt;
    dn_ok_r    <= dn_ok_nxt;
    status_r   <= status_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* hdl/vfra_checker.sv */
// Port-level checker for the variable frame ring allocator, bound to the top level.
// Depends on vfra_pkg.
`default_nettype none
module vfra_checker (
  input wire          clk,
  input wire          rst_n,
  input wire          in_tvalid,
  input wire          in_tready,
  input wire          out_tvalid,
  input wire          out_tready,
  input wire [1:0]    out_tuser,
  input wire [103:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_fail_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != vfra_pkg::ST_OK |-> out_tdata[48:17] == 32'd0)
    else $error("failed action reports a sequence number");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer taken while an action is in flight");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during header clearing");

endmodule

bind variable_frame_ring_allocator vfra_checker u_vfra_checker (.*);
`default_nettype wire
